### rtl/core/bpe_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic patch evaluator package
// Shared types, constants and fixed point helpers.
// ----------------------------------------------------------------------------
package bpe_pkg;

	localparam int WFRAC = 24;
	localparam int PFRAC = 15;
	localparam logic [15:0] PARAM_ONE = 16'd32768;
	localparam logic signed [31:0] RECIP3 = 32'sd89478486;
	localparam int RECIP3_SHIFT = 28;

	localparam logic signed [3:0] COEF [2][4][4] = '{
		'{'{4'sd1, -4'sd3, 4'sd3, -4'sd1}, '{4'sd0, 4'sd3, -4'sd6, 4'sd3},
		  '{4'sd0, 4'sd0, 4'sd3, -4'sd3}, '{4'sd0, 4'sd0, 4'sd0, 4'sd1}},
		'{'{4'sd1, -4'sd3, 4'sd3, -4'sd1}, '{4'sd4, 4'sd0, -4'sd6, 4'sd3},
		  '{4'sd1, 4'sd3, 4'sd3, -4'sd3}, '{4'sd0, 4'sd0, 4'sd0, 4'sd1}}
	};

	typedef enum logic [3:0] {
		ST_IDLE, ST_TPOW, ST_WGT, ST_WDIV, ST_ACC, ST_AXEND, ST_SCALE,
		ST_CROSS, ST_SQ, ST_SQRT, ST_NDIV, ST_DONE
	} bpe_state_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} bpe_point_t;

	typedef struct packed {
		logic       en;
		logic [3:0] idx;
		bpe_point_t pt;
	} bpe_wr_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               degenerate;
	} bpe_res_t;

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] q;
		m = abs64(x);
		q = (m + (64'd1 << (WFRAC - 1))) >> WFRAC;
		return x[63] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [51:0] cmul(input logic signed [3:0] c,
		input logic signed [51:0] x);
		logic [2:0] cm;
		logic signed [51:0] p;
		cm = c[3] ? 3'(-c) : c[2:0];
		p = (cm[0] ? x : 52'sd0) + (cm[1] ? (x <<< 1) : 52'sd0)
			+ (cm[2] ? (x <<< 2) : 52'sd0);
		return c[3] ? -p : p;
	endfunction

endpackage

### rtl/core/bpe_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by the multiply steps.
// ----------------------------------------------------------------------------
module bpe_mul (
	input  logic               clk,
	input  logic signed [37:0] a,
	input  logic signed [31:0] b,
	output logic signed [69:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= 70'(a) * 70'(b);
	end
endmodule

### rtl/core/bpe_ctrl_store.sv
// ----------------------------------------------------------------------------
// Control point store
// Sixteen control points, one write port and one read port.
// ----------------------------------------------------------------------------
module bpe_ctrl_store (
	input  logic                clk,
	input  logic                arst_n,
	input  bpe_pkg::bpe_wr_t    wr,
	input  logic [3:0]          rd_idx,
	output bpe_pkg::bpe_point_t rd_pt
);
	import bpe_pkg::*;

	bpe_point_t pts_q [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				pts_q[k] <= '0;
			end
		end else if (wr.en) begin
			pts_q[wr.idx] <= wr.pt;
		end
	end

	assign rd_pt = pts_q[rd_idx];
endmodule

### rtl/core/bpe_core.sv
// ----------------------------------------------------------------------------
// Evaluation sequencer
// Steps the shared multiplier through basis weights, grid sums, cross
// product and normalization for one evaluate request.
// ----------------------------------------------------------------------------
module bpe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                basis_sel,
	input  logic                start,
	input  logic [15:0]         u_in,
	input  logic [15:0]         v_in,
	input  logic                take,
	output logic                idle,
	output logic                res_valid,
	output bpe_pkg::bpe_res_t   res,
	output logic [3:0]          rd_idx,
	input  bpe_pkg::bpe_point_t rd_pt
);
	import bpe_pkg::*;

	localparam logic [1:0] TGT_PU = 2'd0;
	localparam logic [1:0] TGT_PV = 2'd1;
	localparam logic [1:0] TGT_C  = 2'd2;

	bpe_state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic       ph_q;
	logic [3:0] st_q;
	logic [1:0] i_q;
	logic [1:0] ax_q;
	logic [1:0] tgt_q;

	logic [15:0] tu_q, tv_q;
	logic [30:0] t2u_q, t2v_q;
	logic [45:0] t3u_q, t3v_q;
	logic signed [27:0] w_q [4][4];
	logic [26:0] n_q;
	logic        neg_q;
	logic signed [63:0] rpa_q, rda_q, sp_q, su_q, sv_q;
	logic signed [37:0] rp_q, rd_q;
	logic signed [31:0] pos_q [3];
	logic signed [39:0] pu_q [3];
	logic signed [39:0] pv_q [3];
	logic signed [31:0] pus_q [3];
	logic signed [31:0] pvs_q [3];
	logic signed [63:0] scv_q [3];
	logic [63:0] ss_q, x_q, r_q, bit_q;
	logic [31:0] rem_q;
	logic [15:0] lo_q, q_q;
	logic signed [15:0] norm_q [3];
	logic        degen_q;

	logic signed [37:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [69:0] prod;
	logic signed [63:0] p64;

	logic        wsel;
	logic        wder;
	logic [15:0] wt;
	logic [30:0] wt2;
	logic [45:0] wt3;
	logic signed [51:0] tp0, tp1, tp2, tp3, x0, x1, x2, x3, wa;
	logic [51:0] wmag;
	logic [51:0] wbz;
	logic [51:0] wbs;
	logic signed [27:0] wbez;
	logic [27:0] wdq;

	logic signed [31:0] gsel;
	logic [63:0] m0, m1, m2, mx;
	logic        scl_done;
	logic signed [63:0] scl_v [3];

	logic [63:0] sx, sr, sb, ssum;
	logic [44:0] dvd;
	logic [32:0] trial;
	logic        qbit;
	logic [15:0] qn;

	bpe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign p64 = prod[63:0];
	assign idle = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign rd_idx = {i_q, st_q[2:1]};

	always_comb begin
		case (ax_q)
			2'd0: gsel = rd_pt.x;
			2'd1: gsel = rd_pt.y;
			default: gsel = rd_pt.z;
		endcase
	end

	// Basis weight for the entry selected by cnt_q.
	always_comb begin
		wsel = cnt_q[3];
		wder = cnt_q[2];
		wt   = wsel ? tv_q : tu_q;
		wt2  = wsel ? t2v_q : t2u_q;
		wt3  = wsel ? t3v_q : t3u_q;
		tp0  = 52'sd1 <<< 45;
		tp1  = $signed(52'(wt) << 30);
		tp2  = $signed(52'(wt2) << 15);
		tp3  = $signed(52'(wt3));
		x0   = wder ? 52'sd0 : tp0;
		x1   = wder ? tp0 : tp1;
		x2   = wder ? (tp1 <<< 1) : tp2;
		x3   = wder ? (tp2 + (tp2 <<< 1)) : tp3;
		wa   = cmul(COEF[basis_sel][cnt_q[1:0]][0], x0)
			+ cmul(COEF[basis_sel][cnt_q[1:0]][1], x1)
			+ cmul(COEF[basis_sel][cnt_q[1:0]][2], x2)
			+ cmul(COEF[basis_sel][cnt_q[1:0]][3], x3);
		wmag = wa[51] ? 52'(-wa) : 52'(wa);
		wbz  = (wmag + (52'd1 << 20)) >> 21;
		wbs  = (wmag + (52'd3 << 21)) >> 22;
		wbez = wa[51] ? -$signed(wbz[27:0]) : $signed(wbz[27:0]);
		wdq  = prod[RECIP3_SHIFT +: 28];
	end

	// Power of two scaling of the working vector.
	always_comb begin
		m0 = abs64(scv_q[0]);
		m1 = abs64(scv_q[1]);
		m2 = abs64(scv_q[2]);
		mx = m0;
		if (m1 > mx) begin
			mx = m1;
		end
		if (m2 > mx) begin
			mx = m2;
		end
		scl_done = (mx == 64'd0) || (mx[63:30] == '0 && mx[29]);
		for (int k = 0; k < 3; k++) begin
			if (mx[63:30] != '0) begin
				scl_v[k] = $signed(scv_q[k] + 64'(scv_q[k][63])) >>> 1;
			end else begin
				scl_v[k] = scv_q[k] <<< 1;
			end
		end
	end

	// Square root step and division step.
	always_comb begin
		sx = (cnt_q == 5'd0) ? ss_q : x_q;
		sr = (cnt_q == 5'd0) ? 64'd0 : r_q;
		sb = (cnt_q == 5'd0) ? (64'd1 << 62) : bit_q;
		ssum = sr + sb;
		dvd = 45'(abs64(scv_q[ax_q]) << 14) + 45'(r_q[30:1]);
		trial = {rem_q, lo_q[15]};
		qbit = (trial >= 33'(r_q[30:0]));
		qn = {q_q[14:0], qbit};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TPOW: begin
				case (cnt_q[1:0])
					2'd0: begin mul_a = 38'(tu_q); mul_b = 32'(tu_q); end
					2'd1: begin mul_a = 38'(t2u_q); mul_b = 32'(tu_q); end
					2'd2: begin mul_a = 38'(tv_q); mul_b = 32'(tv_q); end
					default: begin mul_a = 38'(t2v_q); mul_b = 32'(tv_q); end
				endcase
			end
			ST_WDIV: begin
				mul_a = 38'(n_q);
				mul_b = RECIP3;
			end
			ST_ACC: begin
				case (st_q)
					4'd9: begin mul_a = rp_q; mul_b = 32'(w_q[0][i_q]); end
					4'd10: begin mul_a = rp_q; mul_b = 32'(w_q[1][i_q]); end
					4'd11: begin mul_a = rd_q; mul_b = 32'(w_q[0][i_q]); end
					default: begin
						mul_a = 38'(gsel);
						mul_b = 32'(w_q[st_q[0] ? 2'd3 : 2'd2][st_q[2:1]]);
					end
				endcase
			end
			ST_CROSS: begin
				case (cnt_q[2:0])
					3'd0: begin mul_a = 38'(pus_q[1]); mul_b = pvs_q[2]; end
					3'd1: begin mul_a = 38'(pus_q[2]); mul_b = pvs_q[1]; end
					3'd2: begin mul_a = 38'(pus_q[2]); mul_b = pvs_q[0]; end
					3'd3: begin mul_a = 38'(pus_q[0]); mul_b = pvs_q[2]; end
					3'd4: begin mul_a = 38'(pus_q[0]); mul_b = pvs_q[1]; end
					default: begin mul_a = 38'(pus_q[1]); mul_b = pvs_q[0]; end
				endcase
			end
			ST_SQ: begin
				mul_a = scv_q[cnt_q[1:0]][37:0];
				mul_b = scv_q[cnt_q[1:0]][31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_TPOW;
			ST_TPOW: if (ph_q && cnt_q[1:0] == 2'd3) state_d = ST_WGT;
			ST_WGT: begin
				if (basis_sel) begin
					state_d = ST_WDIV;
				end else if (cnt_q[3:0] == 4'd15) begin
					state_d = ST_ACC;
				end
			end
			ST_WDIV: begin
				if (ph_q) begin
					state_d = (cnt_q[3:0] == 4'd15) ? ST_ACC : ST_WGT;
				end
			end
			ST_ACC: if (ph_q && st_q == 4'd11 && i_q == 2'd3) state_d = ST_AXEND;
			ST_AXEND: state_d = (ax_q == 2'd2) ? ST_SCALE : ST_ACC;
			ST_SCALE: begin
				if (scl_done) begin
					if (tgt_q == TGT_C) begin
						state_d = (mx == 64'd0) ? ST_DONE : ST_SQ;
					end else if (tgt_q == TGT_PV) begin
						state_d = ST_CROSS;
					end
				end
			end
			ST_CROSS: if (ph_q && cnt_q[2:0] == 3'd5) state_d = ST_SCALE;
			ST_SQ: if (ph_q && cnt_q[1:0] == 2'd2) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == 5'd31) state_d = ST_NDIV;
			ST_NDIV: if (cnt_q == 5'd16 && ax_q == 2'd2) state_d = ST_DONE;
			ST_DONE: if (take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ph_q  <= 1'b0;
			st_q  <= '0;
			i_q   <= '0;
			ax_q  <= '0;
			tgt_q <= TGT_PU;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					ph_q  <= 1'b0;
					st_q  <= '0;
					i_q   <= '0;
					ax_q  <= '0;
					tgt_q <= TGT_PU;
				end
				ST_TPOW, ST_WDIV, ST_CROSS, ST_SQ: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if ((state_q == ST_TPOW && cnt_q == 5'd3)
							|| (state_q == ST_WDIV && cnt_q == 5'd15)
							|| (state_q == ST_CROSS && cnt_q == 5'd5)
							|| (state_q == ST_SQ && cnt_q == 5'd2)) begin
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_WGT: begin
					if (!basis_sel) begin
						cnt_q <= (cnt_q == 5'd15) ? 5'd0 : cnt_q + 5'd1;
					end
				end
				ST_ACC: begin
					if (st_q == 4'd8) begin
						st_q <= 4'd9;
					end else begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							if (st_q == 4'd11) begin
								st_q <= '0;
								i_q  <= i_q + 2'd1;
							end else begin
								st_q <= st_q + 4'd1;
							end
						end
					end
				end
				ST_AXEND: ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				ST_SCALE: begin
					if (scl_done) begin
						if (tgt_q == TGT_PU) begin
							tgt_q <= TGT_PV;
						end else if (tgt_q == TGT_PV) begin
							tgt_q <= TGT_C;
						end
					end
				end
				ST_SQRT: cnt_q <= cnt_q + 5'd1;
				ST_NDIV: begin
					if (cnt_q == 5'd16) begin
						cnt_q <= '0;
						ax_q  <= ax_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					tu_q    <= (u_in > PARAM_ONE) ? PARAM_ONE : u_in;
					tv_q    <= (v_in > PARAM_ONE) ? PARAM_ONE : v_in;
					degen_q <= 1'b0;
					for (int k = 0; k < 3; k++) begin
						norm_q[k] <= '0;
					end
				end
			end
			ST_TPOW: begin
				if (ph_q) begin
					case (cnt_q[1:0])
						2'd0: t2u_q <= prod[30:0];
						2'd1: t3u_q <= prod[45:0];
						2'd2: t2v_q <= prod[30:0];
						default: t3v_q <= prod[45:0];
					endcase
				end
			end
			ST_WGT: begin
				if (basis_sel) begin
					n_q   <= wbs[26:0];
					neg_q <= wa[51];
				end else begin
					w_q[cnt_q[3:2]][cnt_q[1:0]] <= wbez;
				end
			end
			ST_WDIV: begin
				if (ph_q) begin
					w_q[cnt_q[3:2]][cnt_q[1:0]] <= neg_q ? -$signed(wdq) : $signed(wdq);
				end
			end
			ST_ACC: begin
				if (st_q == 4'd8) begin
					rp_q <= 38'(rnd24(rpa_q));
					rd_q <= 38'(rnd24(rda_q));
				end else if (ph_q) begin
					case (st_q)
						4'd0: rpa_q <= p64;
						4'd1: rda_q <= p64;
						4'd2, 4'd4, 4'd6: rpa_q <= rpa_q + p64;
						4'd3, 4'd5, 4'd7: rda_q <= rda_q + p64;
						4'd9: sp_q <= ((i_q == 2'd0) ? 64'sd0 : sp_q) + p64;
						4'd10: su_q <= ((i_q == 2'd0) ? 64'sd0 : su_q) + p64;
						default: sv_q <= ((i_q == 2'd0) ? 64'sd0 : sv_q) + p64;
					endcase
				end
			end
			ST_AXEND: begin
				pos_q[ax_q] <= sat32(rnd24(sp_q));
				pu_q[ax_q]  <= 40'(rnd24(su_q));
				pv_q[ax_q]  <= 40'(rnd24(sv_q));
				if (ax_q == 2'd2) begin
					scv_q[0] <= 64'(pu_q[0]);
					scv_q[1] <= 64'(pu_q[1]);
					scv_q[2] <= rnd24(su_q);
				end
			end
			ST_SCALE: begin
				if (!scl_done) begin
					for (int k = 0; k < 3; k++) begin
						scv_q[k] <= scl_v[k];
					end
				end else if (tgt_q == TGT_PU) begin
					for (int k = 0; k < 3; k++) begin
						pus_q[k] <= scv_q[k][31:0];
						scv_q[k] <= 64'(pv_q[k]);
					end
				end else if (tgt_q == TGT_PV) begin
					for (int k = 0; k < 3; k++) begin
						pvs_q[k] <= scv_q[k][31:0];
					end
				end else if (mx == 64'd0) begin
					degen_q <= 1'b1;
				end
			end
			ST_CROSS: begin
				if (ph_q) begin
					scv_q[cnt_q[2:1]] <= cnt_q[0] ? (scv_q[cnt_q[2:1]] - p64) : p64;
				end
			end
			ST_SQ: begin
				if (ph_q) begin
					ss_q <= ((cnt_q == 5'd0) ? 64'd0 : ss_q) + 64'(p64);
				end
			end
			ST_SQRT: begin
				if (sx >= ssum) begin
					x_q <= sx - ssum;
					r_q <= (sr >> 1) + sb;
				end else begin
					x_q <= sx;
					r_q <= sr >> 1;
				end
				bit_q <= sb >> 2;
			end
			ST_NDIV: begin
				if (cnt_q == 5'd0) begin
					rem_q <= 32'(dvd[44:16]);
					lo_q  <= dvd[15:0];
					q_q   <= '0;
				end else begin
					rem_q <= qbit ? 32'(trial - 33'(r_q[30:0])) : trial[31:0];
					lo_q  <= {lo_q[14:0], 1'b0};
					q_q   <= qn;
					if (cnt_q == 5'd16) begin
						norm_q[ax_q] <= scv_q[ax_q][63] ? $signed(qn) : -$signed(qn);
					end
				end
			end
			default: begin
				degen_q <= degen_q;
			end
		endcase
	end

	assign res.pos_x = pos_q[0];
	assign res.pos_y = pos_q[1];
	assign res.pos_z = pos_q[2];
	assign res.norm_x = norm_q[0];
	assign res.norm_y = norm_q[1];
	assign res.norm_z = norm_q[2];
	assign res.degenerate = degen_q;

	a_wdiv_bspline: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WDIV) |-> basis_sel)
		else $error("Reciprocal step entered with the Bezier basis.");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && degen_q) |->
		(norm_q[0] == 16'sd0 && norm_q[1] == 16'sd0 && norm_q[2] == 16'sd0))
		else $error("Degenerate result carries a nonzero normal.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NDIV) |-> (r_q[30:29] != 2'b00 && r_q[63:31] == '0))
		else $error("Normal length is out of its scaled range.");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_TPOW))
		else $error("Evaluation did not begin after a start.");
endmodule

### rtl/core/bicubic_patch_evaluator_top.sv
// ----------------------------------------------------------------------------
// Bicubic patch evaluator
// The time from taking an evaluate transfer to its result is set by the single
// shared multiplier, the scaling shifts, a 32-step square root and three
// divisions; the B-spline basis adds a reciprocal step for each weight.
// One evaluation is in flight at a time; the next transfer can be taken in the
// cycle after the finished result moves into the output register.
// Reset clears all control points to zero and selects the Bezier basis.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic [15:0]        u_param,
	input  logic [15:0]        v_param,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic               degenerate
);
	import bpe_pkg::*;

	logic       basis_q;
	logic       idle;
	logic       res_valid;
	logic       take;
	logic       start;
	logic [3:0] rd_idx;
	bpe_res_t   res;
	bpe_res_t   out_q;
	logic       out_valid_q;
	bpe_wr_t    wr;
	bpe_point_t rd_pt;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign start     = in_valid && in_ready && op;
	assign take      = res_valid && !out_valid_q;

	assign wr.en     = in_valid && in_ready && !op;
	assign wr.idx    = {row, col};
	assign wr.pt.x   = px;
	assign wr.pt.y   = py;
	assign wr.pt.z   = pz;

	bpe_ctrl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd_pt  (rd_pt)
	);

	bpe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.basis_sel (basis_q),
		.start     (start),
		.u_in      (u_param),
		.v_in      (v_param),
		.take      (take),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.rd_idx    (rd_idx),
		.rd_pt     (rd_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				basis_q <= cfg_data;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = out_q.pos_x;
	assign pos_y      = out_q.pos_y;
	assign pos_z      = out_q.pos_z;
	assign norm_x     = out_q.norm_x;
	assign norm_y     = out_q.norm_y;
	assign norm_z     = out_q.norm_z;
	assign degenerate = out_q.degenerate;
endmodule
